// ----- rtl/jhc_pkg.sv -----
// shared types and constants for the jet heatmap colorizer
package jhc_pkg;

  localparam int T_W  = 16;
  localparam int CH_W = 8;

  localparam logic [T_W-1:0]  T_MAX        = '1;
  localparam logic [CH_W-1:0] ALPHA_OPAQUE = '1;

  localparam logic CMD_MEASURE = 1'b0;
  localparam logic CMD_MAP     = 1'b1;

  // jet offsets in units of one
  localparam logic [1:0] K_RED   = 2'd3;
  localparam logic [1:0] K_GREEN = 2'd2;
  localparam logic [1:0] K_BLUE  = 2'd1;

  // color pass steps
  localparam logic [1:0] STEP_RED   = 2'd0;
  localparam logic [1:0] STEP_GREEN = 2'd1;
  localparam logic [1:0] STEP_BLUE  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_COLOR,
    ST_LOAD
  } jhc_state_t;

endpackage

// ----- rtl/jhc_if.sv -----
// valid/ready channel interfaces for samples and rgba pixels
interface jhc_in_if #(parameter int SAMPLE_WIDTH = 16);
  logic                    valid;
  logic                    ready;
  logic                    command;
  logic                    frame_start;
  logic [SAMPLE_WIDTH-1:0] sample;
  logic                    sample_finite;

  modport source (output valid, command, frame_start, sample, sample_finite, input ready);
  modport sink   (input valid, command, frame_start, sample, sample_finite, output ready);
endinterface

interface jhc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;

  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

// ----- rtl/jhc_div.sv -----
// radix-2 restoring divider producing a q0.16 fraction of dividend over divisor
module jhc_div
  import jhc_pkg::*;
#(
  parameter int W = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start_i,
  input  logic [W-1:0]   dividend_i,
  input  logic [W-1:0]   divisor_i,
  output logic           done_o,
  output logic [T_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(T_W);

  logic [W-1:0]     rem_r;
  logic [W-1:0]     divisor_r;
  logic [T_W-1:0]   q_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [W:0]   shifted;
  logic [W:0]   diff;
  logic         ge;
  logic [W-1:0] rem_nxt;

  always_comb begin
    shifted = {rem_r, 1'b0};
    diff    = shifted - {1'b0, divisor_r};
    ge      = shifted >= {1'b0, divisor_r};
    rem_nxt = ge ? diff[W-1:0] : shifted[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(T_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      rem_r     <= dividend_i;
      divisor_r <= divisor_i;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[T_W-2:0], ge};
    end
  end

  assign done_o = done_r;
  assign quot_o = q_r;

endmodule

// ----- rtl/jhc_color.sv -----
// one jet channel: clamp(1.5 - |4t - k|, 0, 1) * 255 rounded half up
module jhc_color
  import jhc_pkg::*;
(
  input  logic [T_W-1:0]  t_i,
  input  logic [1:0]      k_i,
  output logic [CH_W-1:0] level_o
);

  localparam logic signed [19:0] X_PEAK = 20'sd98304;
  localparam logic signed [19:0] X_ONE  = 20'sd65536;

  logic signed [19:0] d;
  logic signed [19:0] ad;
  logic signed [19:0] x;
  logic [16:0]        xc;
  logic [24:0]        scaled;

  always_comb begin
    d  = $signed({2'b00, t_i, 2'b00}) - $signed({2'b00, k_i, 16'h0000});
    ad = d[19] ? -d : d;
    x  = X_PEAK - ad;
    if (x[19]) begin
      xc = '0;
    end else if (x > X_ONE) begin
      xc = 17'h10000;
    end else begin
      xc = x[16:0];
    end
    scaled  = {xc, 8'h00} - {8'h00, xc} + 25'd32768;
    level_o = scaled[23:16];
  end

endmodule

// ----- rtl/jet_heatmap_colorizer.sv -----
// top level: min/max measurement, sequencer and output register of the colorizer
//
// in_ch carries samples with a command bit. a measure transaction (command 0)
// folds a finite sample into the frame minimum and maximum; frame_start
// restarts both from that sample. it completes in the cycle it is accepted
// and produces no output. a map transaction (command 1) normalizes the sample
// against the stored range and returns one rgba pixel on out_ch, alpha 255.
// a map transaction occupies the block from the accept through 16 steps of
// the shared restoring divider (one quotient bit per cycle), the handover of
// the quotient, the shared channel unit stepping through red, green and blue,
// and the load of the output register; the pixel is valid once that register
// is loaded. samples needing no division (clamped or zero fraction) skip the
// divider. in_ch.ready is high only while idle.
// the output register holds a pixel until out_ch.ready takes it; the block
// keeps accepting measure transactions and starts the next map meanwhile,
// stalling only when a new pixel is finished while the old one still waits.
// synchronous active-low reset clears min, max and the seen flag to zero and
// empties the output register.
module jet_heatmap_colorizer
  import jhc_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16
) (
  input logic      clk,
  input logic      rst_n,
  jhc_in_if.sink   in_ch,
  jhc_out_if.source out_ch
);

  localparam int SW = SAMPLE_WIDTH;

  jhc_state_t state_r, state_nxt;

  logic signed [SW-1:0] min_r;
  logic signed [SW-1:0] max_r;
  logic                 seen_r;
  logic [T_W-1:0]       t_r;
  logic [1:0]           step_r;
  logic [CH_W-1:0]      red_r;
  logic [CH_W-1:0]      green_r;
  logic [CH_W-1:0]      blue_r;
  logic                 out_valid_r;
  logic [CH_W-1:0]      out_red_r;
  logic [CH_W-1:0]      out_green_r;
  logic [CH_W-1:0]      out_blue_r;

  logic signed [SW:0] diff_w;
  logic signed [SW:0] range_w;
  logic               norm_ok;
  logic               map_div;
  logic               map_sat;
  logic               accept;
  logic               is_map;
  logic               div_start;
  logic               div_done;
  logic [T_W-1:0]     quot;
  logic [1:0]         k_sel;
  logic [CH_W-1:0]    level;
  logic               in_ready;
  logic               out_load;
  logic               step_last;

  assign accept = in_ch.valid && in_ready;
  assign is_map = in_ch.command == CMD_MAP;

  always_comb begin
    diff_w  = $signed({in_ch.sample[SW-1], in_ch.sample}) - $signed({min_r[SW-1], min_r});
    range_w = $signed({max_r[SW-1], max_r}) - $signed({min_r[SW-1], min_r});
    norm_ok = in_ch.sample_finite && seen_r && (range_w > 0);
    map_sat = norm_ok && (diff_w >= range_w);
    map_div = norm_ok && (diff_w > 0) && (diff_w < range_w);
  end

  assign step_last = step_r == STEP_BLUE;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && is_map) state_nxt = map_div ? ST_DIV : ST_COLOR;
      end
      ST_DIV: begin
        if (div_done) state_nxt = ST_COLOR;
      end
      ST_COLOR: begin
        if (step_last) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = state_r == ST_IDLE;
    div_start = (state_r == ST_IDLE) && accept && is_map && map_div;
    out_load  = (state_r == ST_LOAD) && (!out_valid_r || out_ch.ready);
  end

  always_comb begin
    case (step_r)
      STEP_RED:   k_sel = K_RED;
      STEP_GREEN: k_sel = K_GREEN;
      STEP_BLUE:  k_sel = K_BLUE;
      default:    k_sel = K_BLUE;
    endcase
  end

  jhc_div #(.W(SW)) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (div_start),
    .dividend_i (diff_w[SW-1:0]),
    .divisor_i  (range_w[SW-1:0]),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  jhc_color u_color (
    .t_i     (t_r),
    .k_i     (k_sel),
    .level_o (level)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      min_r       <= '0;
      max_r       <= '0;
      seen_r      <= 1'b0;
      step_r      <= STEP_RED;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept && !is_map) begin
        if (in_ch.frame_start) begin
          seen_r <= in_ch.sample_finite;
          min_r  <= in_ch.sample_finite ? in_ch.sample : '0;
          max_r  <= in_ch.sample_finite ? in_ch.sample : '0;
        end else if (in_ch.sample_finite) begin
          if (!seen_r) begin
            seen_r <= 1'b1;
            min_r  <= in_ch.sample;
            max_r  <= in_ch.sample;
          end else begin
            if ($signed(in_ch.sample) < min_r) min_r <= in_ch.sample;
            if ($signed(in_ch.sample) > max_r) max_r <= in_ch.sample;
          end
        end
      end
      if (state_r == ST_COLOR) begin
        step_r <= step_last ? STEP_RED : step_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && accept && is_map) begin
      t_r <= map_sat ? T_MAX : '0;
    end else if (state_r == ST_DIV && div_done) begin
      t_r <= quot;
    end
    if (state_r == ST_COLOR) begin
      case (step_r)
        STEP_RED:   red_r   <= level;
        STEP_GREEN: green_r <= level;
        default:    blue_r  <= level;
      endcase
    end
    if (out_load) begin
      out_red_r   <= red_r;
      out_green_r <= green_r;
      out_blue_r  <= blue_r;
    end
  end

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.red   = out_red_r;
  assign out_ch.green = out_green_r;
  assign out_ch.blue  = out_blue_r;
  assign out_ch.alpha = ALPHA_OPAQUE;

`ifndef SYNTHESIS
  a_unseen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !seen_r |-> (min_r == '0 && max_r == '0))
    else $error("min/max not zero while no finite sample seen");

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r |-> (min_r <= max_r))
    else $error("frame minimum above maximum");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider finished outside the division phase");

  a_load_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD && out_valid_r && !out_ch.ready) |=> state_r == ST_LOAD)
    else $error("pixel dropped while output register occupied");
`endif

endmodule
